// ----- sv/mtt_pkg.sv -----
// Shared types and constants for the markup tag tokenizer.
// Used by mtt_front, mtt_queue, mtt_back and markup_tag_tokenizer; no dependencies.
package mtt_pkg;

    localparam int TOKEN_CAPACITY_DEF = 1024;
    localparam int LEN_W = 11;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] EV_TEXT  = 2'd0;
    localparam logic [1:0] EV_BYTE  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;
    localparam logic [1:0] EV_NOVAL = 2'd3;

    localparam logic [1:0] KIND_TAG  = 2'd0;
    localparam logic [1:0] KIND_ATTR = 2'd1;
    localparam logic [1:0] KIND_VAL  = 2'd2;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // One queued record; noval means a value-absent word follows this one.
    typedef struct packed {
        logic [1:0]       ev;
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] length;
        logic             ovf;
        logic             noval;
    } t_rec;

endpackage

// ----- sv/mtt_front.sv -----
// Front end of the tokenizer: parser state machine and token length counter.
// Depends on mtt_pkg; produces at most one record per accepted byte.
module mtt_front
    import mtt_pkg::*;
#(
    parameter int TOKEN_CAPACITY = TOKEN_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_rec       o_rec
);

    localparam int CNT_W = $clog2(TOKEN_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(TOKEN_CAPACITY);

    typedef enum logic [3:0] {
        ST_TEXT       = 4'd0,
        ST_TAGNAME    = 4'd1,
        ST_ATTRNAME   = 4'd2,
        ST_VALUE      = 4'd3,
        ST_SKIP       = 4'd4,
        ST_WAIT_NAME  = 4'd5,
        ST_WAIT_EQ    = 4'd6,
        ST_WAIT_QUOTE = 4'd7,
        ST_WAIT_GT    = 4'd8
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;

    logic             act_text, act_store, act_finish, act_noval;
    logic [1:0]       act_kind;
    logic             rec_vld;
    t_rec             rec;
    logic [CNT_W+LEN_W-1:0] len_ext;

    assign len_ext = {{LEN_W{1'b0}}, r_count};

    always_comb begin
        act_text   = 1'b0;
        act_store  = 1'b0;
        act_finish = 1'b0;
        act_noval  = 1'b0;
        act_kind   = KIND_TAG;
        n_state    = r_state;
        unique case (r_state)
            ST_TAGNAME: begin
                act_kind = KIND_TAG;
                if (i_byte == CH_SLASH) begin
                    act_finish = 1'b1;
                    n_state    = ST_WAIT_GT;
                end else if (i_byte == CH_GT) begin
                    act_finish = 1'b1;
                    n_state    = ST_TEXT;
                end else if (i_byte == CH_SPACE) begin
                    act_finish = 1'b1;
                    n_state    = ST_WAIT_NAME;
                end else begin
                    act_store = 1'b1;
                end
            end
            ST_ATTRNAME: begin
                act_kind = KIND_ATTR;
                if (i_byte == CH_EQ) begin
                    act_finish = 1'b1;
                    n_state    = ST_WAIT_QUOTE;
                end else if (i_byte == CH_SPACE) begin
                    act_finish = 1'b1;
                    n_state    = ST_WAIT_EQ;
                end else if (i_byte == CH_SLASH || i_byte == CH_GT) begin
                    act_finish = 1'b1;
                    act_noval  = 1'b1;
                    n_state    = (i_byte == CH_SLASH) ? ST_WAIT_GT : ST_TEXT;
                end else begin
                    act_store = 1'b1;
                end
            end
            ST_VALUE: begin
                act_kind = KIND_VAL;
                if (i_byte == CH_QUOTE) begin
                    act_finish = 1'b1;
                    n_state    = ST_WAIT_NAME;
                end else begin
                    act_store = 1'b1;
                end
            end
            ST_SKIP: begin
                if (i_byte == CH_GT) begin
                    n_state = ST_TEXT;
                end
            end
            ST_WAIT_NAME: begin
                act_kind = KIND_ATTR;
                if (i_byte == CH_SLASH) begin
                    n_state = ST_WAIT_GT;
                end else if (i_byte == CH_GT) begin
                    n_state = ST_TEXT;
                end else if (i_byte != CH_SPACE) begin
                    act_store = 1'b1;
                    n_state   = ST_ATTRNAME;
                end
            end
            ST_WAIT_EQ: begin
                act_kind = KIND_ATTR;
                if (i_byte == CH_EQ) begin
                    n_state = ST_WAIT_QUOTE;
                end else if (i_byte == CH_GT || i_byte == CH_SLASH) begin
                    act_finish = 1'b1;
                    act_noval  = 1'b1;
                    n_state    = (i_byte == CH_SLASH) ? ST_WAIT_GT : ST_TEXT;
                end else begin
                    n_state = ST_SKIP;
                end
            end
            ST_WAIT_QUOTE: begin
                if (i_byte == CH_QUOTE) begin
                    n_state = ST_VALUE;
                end else if (i_byte != CH_SPACE) begin
                    n_state = ST_SKIP;
                end
            end
            ST_WAIT_GT: begin
                n_state = (i_byte == CH_GT) ? ST_TEXT : ST_SKIP;
            end
            default: begin
                if (i_byte == CH_LT) begin
                    n_state = ST_TAGNAME;
                end else begin
                    act_text = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        rec     = '0;
        rec_vld = 1'b0;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (act_text) begin
            rec_vld  = 1'b1;
            rec.ev   = EV_TEXT;
            rec.data = i_byte;
        end
        if (act_finish) begin
            rec_vld    = 1'b1;
            rec.ev     = EV_END;
            rec.kind   = act_kind;
            rec.length = len_ext[LEN_W-1:0];
            rec.ovf    = r_ovf;
            rec.noval  = act_noval;
            n_count    = '0;
            n_ovf      = 1'b0;
        end
        if (act_store) begin
            if (r_count >= CAP) begin
                n_ovf = 1'b1;
            end else begin
                n_count  = r_count + 1'b1;
                rec_vld  = 1'b1;
                rec.ev   = EV_BYTE;
                rec.kind = act_kind;
                rec.data = i_byte;
            end
        end
    end

    assign o_push = i_accept & rec_vld;
    assign o_rec  = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_TEXT;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ----- sv/mtt_queue.sv -----
// Small record queue between the tokenizer front end and the output stage.
// Depends on mtt_pkg for the record type and depth.
module mtt_queue
    import mtt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_full,
    output logic o_nempty,
    output t_rec o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_rec             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full   = (r_cnt == FULL_CNT);
    assign o_nempty = (r_cnt != '0);
    assign o_head   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- sv/mtt_back.sv -----
// Output stage: expands queued records into result words in a registered output.
// Depends on mtt_pkg; a record with a value-absent flag yields two words.
module mtt_back
    import mtt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_nempty,
    input  t_rec             i_head,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [1:0]       o_event_res,
    output logic [1:0]       o_token_kind,
    output logic [7:0]       o_data_byte,
    output logic [LEN_W-1:0] o_token_length,
    output logic             o_token_overflow,
    output logic             o_last
);

    logic             r_valid, r_phase;
    logic [1:0]       r_ev, r_kind;
    logic [7:0]       r_data;
    logic [LEN_W-1:0] r_len;
    logic             r_ovf, r_last;
    logic             load;

    assign load  = !r_valid || !i_stall;
    assign o_pop = load && i_nempty && (r_phase || !i_head.noval);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= i_nempty;
            if (i_nempty) begin
                r_phase <= !r_phase && i_head.noval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_nempty) begin
            if (r_phase) begin
                r_ev   <= EV_NOVAL;
                r_kind <= KIND_VAL;
                r_data <= '0;
                r_len  <= '0;
                r_ovf  <= 1'b0;
                r_last <= 1'b1;
            end else begin
                r_ev   <= i_head.ev;
                r_kind <= i_head.kind;
                r_data <= i_head.data;
                r_len  <= i_head.length;
                r_ovf  <= i_head.ovf;
                r_last <= !i_head.noval;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_event_res      = r_ev;
    assign o_token_kind     = r_kind;
    assign o_data_byte      = r_data;
    assign o_token_length   = r_len;
    assign o_token_overflow = r_ovf;
    assign o_last           = r_last;

endmodule

// ----- sv/markup_tag_tokenizer.sv -----
// Markup tag tokenizer top level: front parser, record queue and output stage.
// Depends on mtt_pkg, mtt_front, mtt_queue and mtt_back.
// The first result word is written into the queue, then registered in the output stage.
// Throughput is one byte per cycle; a byte with two results yields two output words,
// absorbed by the four-entry queue. The input stalls only when that queue is full.
// Synchronous active-low reset puts the parser in text mode and empties queue and output.
module markup_tag_tokenizer
    import mtt_pkg::*;
#(
    parameter int TOKEN_CAPACITY = TOKEN_CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_in_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_event_res,
    output logic [1:0]       o_token_kind,
    output logic [7:0]       o_data_byte,
    output logic [LEN_W-1:0] o_token_length,
    output logic             o_token_overflow,
    output logic             o_last
);

    logic accept, push, pop, full, nempty;
    t_rec rec, head;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    mtt_front #(
        .TOKEN_CAPACITY(TOKEN_CAPACITY)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_in_byte),
        .o_push  (push),
        .o_rec   (rec)
    );

    mtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_nempty(nempty),
        .o_head  (head)
    );

    mtt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nempty        (nempty),
        .i_head          (head),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_event_res     (o_event_res),
        .o_token_kind    (o_token_kind),
        .o_data_byte     (o_data_byte),
        .o_token_length  (o_token_length),
        .o_token_overflow(o_token_overflow),
        .o_last          (o_last)
    );

endmodule

// ----- test/tb.sv -----
// Testbench for markup_tag_tokenizer: directed table, long tokens and random markup.
// Results are checked against an in-bench tokenizer model; depends on mtt_pkg.
`timescale 1ns / 1ps

module tb;
    import mtt_pkg::*;

    localparam int CAP = TOKEN_CAPACITY_DEF;

    typedef enum logic [3:0] {
        PS_TEXT, PS_TAG, PS_ATTR, PS_VALUE, PS_SKIP,
        PS_WAIT_NAME, PS_WAIT_EQ, PS_WAIT_QUOTE, PS_WAIT_GT
    } parse_t;

    typedef struct packed {
        logic [1:0]       ev;
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             last;
    } word_t;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        int         n;
        word_t      w;
    } row_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [7:0]       i_in_byte = 8'h00;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [1:0]       o_event_res;
    logic [1:0]       o_token_kind;
    logic [7:0]       o_data_byte;
    logic [LEN_W-1:0] o_token_length;
    logic             o_token_overflow;
    logic             o_last;

    markup_tag_tokenizer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_res      (o_event_res),
        .o_token_kind     (o_token_kind),
        .o_data_byte      (o_data_byte),
        .o_token_length   (o_token_length),
        .o_token_overflow (o_token_overflow),
        .o_last           (o_last)
    );

    row_t   rows[$];
    word_t  fresh[$];
    word_t  expected_words[$];
    parse_t mode = PS_TEXT;
    int     tok_len = 0;
    bit     tok_ovf = 1'b0;
    int     failures = 0;
    int     bytes_taken = 0;
    int     next_row = 0;
    int     gap_left = 0;
    int     stall_left = 0;
    bit     calm = 1'b0;
    row_t   shown;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic word_t wd(logic [1:0] ev, logic [1:0] kind, logic [7:0] data,
                                 int len, bit ovf, bit last);
        word_t w;
        w.ev = ev;
        w.kind = kind;
        w.data = data;
        w.len = len[LEN_W-1:0];
        w.ovf = ovf;
        w.last = last;
        return w;
    endfunction

    function automatic void emit_word(logic [1:0] ev, logic [1:0] kind, logic [7:0] data,
                                      int len, bit ovf);
        fresh.push_back(wd(ev, kind, data, len, ovf, 1'b0));
    endfunction

    function automatic void keep_byte(logic [1:0] kind, logic [7:0] c);
        if (tok_len >= CAP) begin
            tok_ovf = 1'b1;
        end else begin
            tok_len++;
            emit_word(EV_BYTE, kind, c, 0, 1'b0);
        end
    endfunction

    function automatic void close_token(logic [1:0] kind);
        emit_word(EV_END, kind, 8'h00, tok_len, tok_ovf);
        tok_len = 0;
        tok_ovf = 1'b0;
    endfunction

    // Advances the tokenizer by one byte and leaves its words in fresh.
    function automatic void tokenize(logic [7:0] c);
        fresh.delete();
        case (mode)
            PS_TAG: begin
                if (c == CH_SLASH || c == CH_GT || c == CH_SPACE) begin
                    close_token(KIND_TAG);
                    mode = (c == CH_SLASH) ? PS_WAIT_GT :
                           (c == CH_GT) ? PS_TEXT : PS_WAIT_NAME;
                end else begin
                    keep_byte(KIND_TAG, c);
                end
            end
            PS_ATTR: begin
                if (c == CH_EQ) begin
                    close_token(KIND_ATTR);
                    mode = PS_WAIT_QUOTE;
                end else if (c == CH_SPACE) begin
                    close_token(KIND_ATTR);
                    mode = PS_WAIT_EQ;
                end else if (c == CH_SLASH || c == CH_GT) begin
                    close_token(KIND_ATTR);
                    emit_word(EV_NOVAL, KIND_VAL, 8'h00, 0, 1'b0);
                    mode = (c == CH_SLASH) ? PS_WAIT_GT : PS_TEXT;
                end else begin
                    keep_byte(KIND_ATTR, c);
                end
            end
            PS_VALUE: begin
                if (c == CH_QUOTE) begin
                    close_token(KIND_VAL);
                    mode = PS_WAIT_NAME;
                end else begin
                    keep_byte(KIND_VAL, c);
                end
            end
            PS_SKIP: begin
                if (c == CH_GT) mode = PS_TEXT;
            end
            PS_WAIT_NAME: begin
                if (c == CH_SLASH) begin
                    mode = PS_WAIT_GT;
                end else if (c == CH_GT) begin
                    mode = PS_TEXT;
                end else if (c != CH_SPACE) begin
                    mode = PS_ATTR;
                    keep_byte(KIND_ATTR, c);
                end
            end
            PS_WAIT_EQ: begin
                if (c == CH_EQ) begin
                    mode = PS_WAIT_QUOTE;
                end else if (c == CH_GT || c == CH_SLASH) begin
                    close_token(KIND_ATTR);
                    emit_word(EV_NOVAL, KIND_VAL, 8'h00, 0, 1'b0);
                    mode = (c == CH_SLASH) ? PS_WAIT_GT : PS_TEXT;
                end else begin
                    mode = PS_SKIP;
                end
            end
            PS_WAIT_QUOTE: begin
                if (c == CH_QUOTE) mode = PS_VALUE;
                else if (c != CH_SPACE) mode = PS_SKIP;
            end
            PS_WAIT_GT: begin
                mode = (c == CH_GT) ? PS_TEXT : PS_SKIP;
            end
            default: begin
                if (c == CH_LT) mode = PS_TAG;
                else emit_word(EV_TEXT, KIND_TAG, c, 0, 1'b0);
            end
        endcase
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    endfunction

    function automatic void add(logic [7:0] b);
        row_t r;
        r.b = b;
        r.typed = 1'b0;
        r.n = 0;
        r.w = '0;
        rows.push_back(r);
    endfunction

    function automatic void add_typed(logic [7:0] b, int n, word_t w);
        row_t r;
        r.b = b;
        r.typed = 1'b1;
        r.n = n;
        r.w = w;
        rows.push_back(r);
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_SLASH || b == CH_GT || b == CH_SPACE || b == CH_EQ || b == CH_QUOTE);
        return b;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_LT);
        return b;
    endfunction

    function automatic logic [7:0] value_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE);
        return b;
    endfunction

    function automatic void add_tag();
        int nattr;
        if ($urandom_range(0, 5) == 0) begin
            add(CH_SLASH);
            repeat ($urandom_range(0, 4)) add(name_byte());
            add(CH_GT);
            return;
        end
        repeat ($urandom_range(0, 5)) add(name_byte());
        nattr = $urandom_range(0, 3);
        for (int a = 0; a < nattr; a++) begin
            repeat ($urandom_range(1, 2)) add(CH_SPACE);
            repeat ($urandom_range(1, 4)) add(name_byte());
            case ($urandom_range(0, 4))
                0, 1: begin
                    add(CH_EQ);
                    add(CH_QUOTE);
                    repeat ($urandom_range(0, 5)) add(value_byte());
                    add(CH_QUOTE);
                end
                2: begin
                    add(CH_SPACE);
                    add(CH_EQ);
                    repeat ($urandom_range(0, 1)) add(CH_SPACE);
                    add(CH_QUOTE);
                    repeat ($urandom_range(0, 5)) add(value_byte());
                    add(CH_QUOTE);
                end
                3: add(CH_SPACE);
                default: ;
            endcase
        end
        case ($urandom_range(0, 3))
            0: begin
                add(CH_SLASH);
                add(CH_GT);
            end
            1: begin
                add(CH_SPACE);
                add(CH_GT);
            end
            default: add(CH_GT);
        endcase
    endfunction

    function automatic void add_broken();
        logic [7:0] pick [8] = '{CH_LT, CH_SLASH, CH_GT, CH_EQ, CH_QUOTE, CH_SPACE, "a", "z"};
        add(CH_LT);
        repeat ($urandom_range(1, 6)) add(pick[$urandom_range(0, 7)]);
    endfunction

    function automatic void build_rows();
        int stop;
        add_typed(8'h00, 1, wd(EV_TEXT, KIND_TAG, 8'h00, 0, 1'b0, 1'b1));
        add_typed(8'hFF, 1, wd(EV_TEXT, KIND_TAG, 8'hFF, 0, 1'b0, 1'b1));
        add_typed(CH_LT, 0, '0);
        add_typed(CH_SLASH, 1, wd(EV_END, KIND_TAG, 8'h00, 0, 1'b0, 1'b1));
        add("q");
        add(CH_GT);
        add(CH_LT);
        add("a");
        add(CH_SPACE);
        add("b");
        add(CH_SPACE);
        add(CH_SLASH);
        add(CH_GT);
        add(CH_LT);
        add(8'h80);
        add(CH_SPACE);
        add("k");
        add(CH_EQ);
        add(CH_SPACE);
        add(CH_QUOTE);
        add(8'h7F);
        add(CH_QUOTE);
        add("m");
        add(CH_GT);

        add(CH_LT);
        repeat (CAP) add(name_byte());
        add(CH_GT);
        add(CH_LT);
        add("p");
        add(CH_SPACE);
        add("v");
        add(CH_EQ);
        add(CH_QUOTE);
        repeat (CAP + 3) add(value_byte());
        add(CH_QUOTE);
        add(CH_GT);

        stop = rows.size() + 800;
        while (rows.size() < stop) begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 6)) add(text_byte());
                8: repeat ($urandom_range(1, 4)) add(8'($urandom_range(0, 255)));
                9: add_broken();
                default: begin
                    add(CH_LT);
                    add_tag();
                end
            endcase
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                tokenize(shown.b);
                if (shown.typed) begin
                    if (shown.n > 0) expected_words.push_back(shown.w);
                end else begin
                    foreach (fresh[k]) expected_words.push_back(fresh[k]);
                end
                bytes_taken++;
                if (bytes_taken % 150 == 0) calm = ($urandom_range(0, 3) == 0);
                gap_left = pick_gap();
            end
            if (i_valid && o_stall) begin
                i_valid <= 1'b1;
            end else if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else if (next_row < rows.size()) begin
                shown = rows[next_row];
                next_row++;
                i_valid <= 1'b1;
                i_in_byte <= shown.b;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        word_t w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: event %0d, data %0d", o_event_res,
                           o_data_byte);
                    failures++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("event_res", w.ev, o_event_res);
                    check_field("token_kind", w.kind, o_token_kind);
                    check_field("data_byte", w.data, o_data_byte);
                    check_field("token_length", w.len, o_token_length);
                    check_field("token_overflow", w.ovf, o_token_overflow);
                    check_field("last", w.last, o_last);
                end
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        build_rows();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (bytes_taken == rows.size());
        for (int k = 0; k < 5000 && expected_words.size() != 0; k++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            failures++;
        end
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $error("timeout after %0d of %0d bytes", bytes_taken, rows.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
